>>> hw/rtl/heqm_pkg.sv
package heqm_pkg;

   // Store geometry and count width.
   localparam int INTENSITY_BITS = 12;
   localparam int COUNT_BITS     = 32;
   localparam int ADDR_W         = INTENSITY_BITS;
   localparam int STORE_DEPTH    = 1 << INTENSITY_BITS;

   // Field widths of the item payloads.
   localparam int OP_W     = 2;
   localparam int IDX_W    = 12;
   localparam int MAP_W    = 12;
   localparam int STAT_W   = 2;
   localparam int BITS_W   = 4;
   localparam int REQ_DW   = ((OP_W + IDX_W + 7) / 8) * 8;
   localparam int RSP_DW   = ((MAP_W + STAT_W + 7) / 8) * 8;
   localparam int CSR_IW   = 1;
   localparam int CSR_DW   = 12;

   // The scale factor 2^bits - 1 and the quotient both fit in INTENSITY_BITS.
   localparam int SCALE_W  = INTENSITY_BITS;
   localparam int PROD_W   = COUNT_BITS + SCALE_W;
   localparam int STEP_W   = $clog2(SCALE_W);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [BITS_W-1:0] BITS_RESET    = BITS_W'(12);
   localparam logic [IDX_W-1:0]  HMAP_RESET    = IDX_W'(4095);

   typedef enum logic [OP_W-1:0] {
      OP_ADD   = 2'd0,
      OP_FINAL = 2'd1,
      OP_QUERY = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_DROPPED   = 2'd1,
      ST_BEYOND    = 2'd2,
      ST_NOT_FINAL = 2'd3
   } status_type;

   typedef enum logic [CSR_IW-1:0] {
      CSR_BITS = 1'b0,
      CSR_HMAP = 1'b1
   } csr_idx_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD_WR,
      S_FIN_RUN,
      S_CLR_RUN,
      S_QRY_CHK,
      S_QRY_DIV,
      S_DONE
   } state_type;

endpackage

>>> hw/rtl/histogram_equalization_map_top.sv
// Histogram equalization map. Items on req_ carry an operation and an
// intensity; every item returns exactly one item on rsp_ with a mapped value
// and a status. Add counts one sample into a 4096 x 32-bit bin memory and
// the voxel total (all counts saturate). Finalize rewrites the memory in
// place as a cumulative distribution and records the first nonzero
// cumulative value. Query returns floor((cdf-cdfmin)*(2^bits-1)/
// (total-cdfmin)), or 0 where cdf is zero or the divisor is zero. Clear
// zeroes the memory, the total, the minimum and the finalized flag. One item
// is worked on at a time, and the next is taken while the previous result
// still waits on rsp_. An add reads the memory, writes it back and hands off
// its result; a rejected item and a repeated finalize go straight to the
// hand-off; a query reads, multiplies, runs 12 steps of a restoring divider
// that yields one quotient bit per cycle and hands off; finalize and clear
// each walk the whole memory. After reset the block sweeps the memory to
// zero with req_tready low; configuration writes are taken throughout.
// bits_allocated and highest_mapped should be written only while the block
// is idle.
module histogram_equalization_map_top (
   input  logic                              clock,
   input  logic                              reset,
   // op [1:0], intensity [13:2], zero [15:14]
   input  logic [heqm_pkg::REQ_DW-1:0]       req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // mapped_value [11:0], status [13:12], zero [15:14]
   output logic [heqm_pkg::RSP_DW-1:0]       rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  logic [heqm_pkg::CSR_IW-1:0]       csr_index,
   input  logic [heqm_pkg::CSR_DW-1:0]       csr_wdata
);

   localparam int AW = heqm_pkg::ADDR_W;
   localparam int CW = heqm_pkg::COUNT_BITS;
   localparam int PW = heqm_pkg::PROD_W;
   localparam int QW = heqm_pkg::SCALE_W;

   // Bin memory: one write port, one registered read port.
   logic [CW-1:0] bin_mem [heqm_pkg::STORE_DEPTH];
   logic [AW-1:0] mem_rd_addr;
   logic [CW-1:0] mem_rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_wr_addr;
   logic [CW-1:0] mem_wr_data;

   heqm_pkg::state_type state_ff, state_in;

   logic [AW:0]                     cnt_ff, cnt_in;
   logic                            fin_v_ff, fin_v_in;
   logic [AW-1:0]                   fin_addr_ff, fin_addr_in;
   logic [CW-1:0]                   run_ff, run_in;
   logic [CW-1:0]                   total_ff, total_in;
   logic [CW-1:0]                   cmin_ff, cmin_in;
   logic                            final_ff, final_in;
   logic                            clr_reply_ff, clr_reply_in;
   logic [AW-1:0]                   idx_ff, idx_in;
   logic [PW-1:0]                   num_ff, num_in;
   logic [PW-1:0]                   dsh_ff, dsh_in;
   logic [QW-1:0]                   q_ff, q_in;
   logic [heqm_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [heqm_pkg::MAP_W-1:0]      res_map_ff, res_map_in;
   heqm_pkg::status_type            res_stat_ff, res_stat_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [heqm_pkg::MAP_W-1:0]      rsp_map_ff, rsp_map_in;
   heqm_pkg::status_type            rsp_stat_ff, rsp_stat_in;
   logic [heqm_pkg::BITS_W-1:0]     bits_ff, bits_in;
   logic [heqm_pkg::IDX_W-1:0]      hmap_ff, hmap_in;

   // Request fields.
   heqm_pkg::op_type               req_op;
   logic [heqm_pkg::IDX_W-1:0]     req_idx;
   logic                           req_fire;

   // Derived values.
   logic [heqm_pkg::BITS_W-1:0]    eff_bits;
   logic [QW-1:0]                  scale;
   logic                           beyond_levels;
   logic                           beyond_store;
   logic [CW:0]                    run_sum;
   logic [CW-1:0]                  run_sat;
   logic [CW-1:0]                  bin_inc;
   logic [CW-1:0]                  total_inc;
   logic [CW-1:0]                  diff;
   logic [CW-1:0]                  den;
   logic                           rem_ge;
   logic [QW-1:0]                  q_next;

   assign req_op  = heqm_pkg::op_type'(req_tdata[heqm_pkg::OP_W-1:0]);
   assign req_idx = req_tdata[heqm_pkg::OP_W +: heqm_pkg::IDX_W];
   assign req_fire = req_tvalid && req_tready;
   assign req_tready = (state_ff == heqm_pkg::S_IDLE);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = heqm_pkg::RSP_DW'({rsp_stat_ff, rsp_map_ff});

   // Effective bit count is clamped to the store's index width.
   assign eff_bits = (bits_ff > heqm_pkg::BITS_W'(heqm_pkg::INTENSITY_BITS))
                   ? heqm_pkg::BITS_W'(heqm_pkg::INTENSITY_BITS) : bits_ff;
   assign scale = {QW{1'b1}} >> (heqm_pkg::BITS_W'(heqm_pkg::INTENSITY_BITS) - eff_bits);
   assign beyond_levels = (req_idx >> eff_bits) != '0;
   assign beyond_store  = (req_idx >> heqm_pkg::INTENSITY_BITS) != '0;

   assign run_sum   = {1'b0, run_ff} + {1'b0, mem_rdata_ff};
   assign run_sat   = run_sum[CW] ? heqm_pkg::COUNT_MAX : run_sum[CW-1:0];
   assign bin_inc   = (mem_rdata_ff == heqm_pkg::COUNT_MAX) ? mem_rdata_ff
                                                            : mem_rdata_ff + CW'(1);
   assign total_inc = (total_ff == heqm_pkg::COUNT_MAX) ? total_ff : total_ff + CW'(1);
   assign diff      = mem_rdata_ff - cmin_ff;
   assign den       = total_ff - cmin_ff;

   // One restoring division step per cycle.
   assign rem_ge = num_ff >= dsh_ff;
   assign q_next = {q_ff[QW-2:0], rem_ge};

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      fin_v_in     = 1'b0;
      fin_addr_in  = fin_addr_ff;
      run_in       = run_ff;
      total_in     = total_ff;
      cmin_in      = cmin_ff;
      final_in     = final_ff;
      clr_reply_in = clr_reply_ff;
      idx_in       = idx_ff;
      num_in       = num_ff;
      dsh_in       = dsh_ff;
      q_in         = q_ff;
      step_in      = step_ff;
      res_map_in   = res_map_ff;
      res_stat_in  = res_stat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_map_in   = rsp_map_ff;
      rsp_stat_in  = rsp_stat_ff;
      mem_rd_addr  = req_idx[AW-1:0];
      mem_we       = 1'b0;
      mem_wr_addr  = idx_ff;
      mem_wr_data  = bin_inc;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         heqm_pkg::S_IDLE: begin
            if (req_fire) begin
               res_map_in  = '0;
               res_stat_in = heqm_pkg::ST_OK;
               idx_in      = req_idx[AW-1:0];
               case (req_op)
                  heqm_pkg::OP_ADD: begin
                     if (final_ff || beyond_levels || beyond_store) begin
                        res_stat_in = heqm_pkg::ST_DROPPED;
                        state_in    = heqm_pkg::S_DONE;
                     end else begin
                        state_in = heqm_pkg::S_ADD_WR;
                     end
                  end
                  heqm_pkg::OP_FINAL: begin
                     if (final_ff) begin
                        state_in = heqm_pkg::S_DONE;
                     end else begin
                        cnt_in   = '0;
                        run_in   = '0;
                        cmin_in  = '0;
                        state_in = heqm_pkg::S_FIN_RUN;
                     end
                  end
                  heqm_pkg::OP_QUERY: begin
                     if (!final_ff) begin
                        res_stat_in = heqm_pkg::ST_NOT_FINAL;
                        state_in    = heqm_pkg::S_DONE;
                     end else if (req_idx > hmap_ff || beyond_store) begin
                        res_stat_in = heqm_pkg::ST_BEYOND;
                        state_in    = heqm_pkg::S_DONE;
                     end else begin
                        state_in = heqm_pkg::S_QRY_CHK;
                     end
                  end
                  default: begin
                     cnt_in       = '0;
                     clr_reply_in = 1'b1;
                     total_in     = '0;
                     cmin_in      = '0;
                     final_in     = 1'b0;
                     state_in     = heqm_pkg::S_CLR_RUN;
                  end
               endcase
            end
         end

         heqm_pkg::S_ADD_WR: begin
            mem_we   = 1'b1;
            total_in = total_inc;
            state_in = heqm_pkg::S_DONE;
         end

         heqm_pkg::S_FIN_RUN: begin
            // Read address runs one entry ahead of the write-back address.
            mem_rd_addr = cnt_ff[AW-1:0];
            if (!cnt_ff[AW]) begin
               fin_v_in    = 1'b1;
               fin_addr_in = cnt_ff[AW-1:0];
               cnt_in      = cnt_ff + (AW+1)'(1);
            end
            if (fin_v_ff) begin
               mem_we      = 1'b1;
               mem_wr_addr = fin_addr_ff;
               mem_wr_data = run_sat;
               run_in      = run_sat;
               if (cmin_ff == '0) begin
                  cmin_in = run_sat;
               end
            end
            if (cnt_ff[AW] && !fin_v_ff) begin
               final_in = 1'b1;
               state_in = heqm_pkg::S_DONE;
            end
         end

         heqm_pkg::S_CLR_RUN: begin
            mem_we      = 1'b1;
            mem_wr_addr = cnt_ff[AW-1:0];
            mem_wr_data = '0;
            cnt_in      = cnt_ff + (AW+1)'(1);
            if (cnt_ff[AW-1:0] == {AW{1'b1}}) begin
               state_in = clr_reply_ff ? heqm_pkg::S_DONE : heqm_pkg::S_IDLE;
            end
         end

         heqm_pkg::S_QRY_CHK: begin
            if (mem_rdata_ff != '0 && total_ff > cmin_ff && mem_rdata_ff >= cmin_ff) begin
               num_in   = PW'(diff) * PW'(scale);
               dsh_in   = PW'(den) << (QW - 1);
               q_in     = '0;
               step_in  = '0;
               state_in = heqm_pkg::S_QRY_DIV;
            end else begin
               state_in = heqm_pkg::S_DONE;
            end
         end

         heqm_pkg::S_QRY_DIV: begin
            if (rem_ge) begin
               num_in = num_ff - dsh_ff;
            end
            dsh_in  = dsh_ff >> 1;
            q_in    = q_next;
            step_in = step_ff + heqm_pkg::STEP_W'(1);
            if (step_ff == heqm_pkg::STEP_W'(QW - 1)) begin
               // The quotient never exceeds 2^bits - 1.
               res_map_in = heqm_pkg::MAP_W'(q_next);
               state_in   = heqm_pkg::S_DONE;
            end
         end

         heqm_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_map_in   = res_map_ff;
               rsp_stat_in  = res_stat_ff;
               state_in     = heqm_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = heqm_pkg::S_IDLE;
         end
      endcase
   end

   // Configuration writes.
   always_comb begin
      bits_in = bits_ff;
      hmap_in = hmap_ff;
      if (csr_we) begin
         case (heqm_pkg::csr_idx_type'(csr_index))
            heqm_pkg::CSR_BITS: bits_in = csr_wdata[heqm_pkg::BITS_W-1:0];
            heqm_pkg::CSR_HMAP: hmap_in = csr_wdata[heqm_pkg::IDX_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bin_mem[mem_wr_addr] <= mem_wr_data;
      end
      mem_rdata_ff <= bin_mem[mem_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= heqm_pkg::S_CLR_RUN;
         cnt_ff       <= '0;
         fin_v_ff     <= 1'b0;
         total_ff     <= '0;
         cmin_ff      <= '0;
         final_ff     <= 1'b0;
         clr_reply_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bits_ff      <= heqm_pkg::BITS_RESET;
         hmap_ff      <= heqm_pkg::HMAP_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fin_v_ff     <= fin_v_in;
         total_ff     <= total_in;
         cmin_ff      <= cmin_in;
         final_ff     <= final_in;
         clr_reply_ff <= clr_reply_in;
         rsp_valid_ff <= rsp_valid_in;
         bits_ff      <= bits_in;
         hmap_ff      <= hmap_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_addr_ff <= fin_addr_in;
      run_ff      <= run_in;
      idx_ff      <= idx_in;
      num_ff      <= num_in;
      dsh_ff      <= dsh_in;
      q_ff        <= q_in;
      step_ff     <= step_in;
      res_map_ff  <= res_map_in;
      res_stat_ff <= res_stat_in;
      rsp_map_ff  <= rsp_map_in;
      rsp_stat_ff <= rsp_stat_in;
   end

endmodule

>>> test/testbench.sv
module testbench;

   // An input item: the operation in the low bits, the intensity above it, which
   // matches the packing of req_tdata.
   typedef struct packed {
      logic [heqm_pkg::IDX_W-1:0] intensity;
      heqm_pkg::op_type           op;
   } eq_req_type;

   // A result item: mapped value in the low bits, status above it, as on rsp_tdata.
   typedef struct packed {
      heqm_pkg::status_type       status;
      logic [heqm_pkg::MAP_W-1:0] mapped;
   } eq_rsp_type;

   localparam int RANDOM_OPS  = 600;
   localparam int LONG_HOLD   = 6000;
   localparam int CYCLE_LIMIT = 2000000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic [heqm_pkg::REQ_DW-1:0]   req_tdata = '0;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [heqm_pkg::RSP_DW-1:0]   rsp_tdata;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic                          csr_we = 1'b0;
   logic [heqm_pkg::CSR_IW-1:0]   csr_index = heqm_pkg::CSR_BITS;
   logic [heqm_pkg::CSR_DW-1:0]   csr_wdata = '0;

   // Shadow copy of the block's state and registers, advanced once per accepted
   // item in the order the block accepts them.
   logic [heqm_pkg::COUNT_BITS-1:0] bin_count [heqm_pkg::STORE_DEPTH];
   logic [heqm_pkg::COUNT_BITS-1:0] sample_total;
   logic [heqm_pkg::COUNT_BITS-1:0] cdf_floor;
   logic                            cdf_ready;
   logic [heqm_pkg::BITS_W-1:0]     bits_cfg;
   logic [heqm_pkg::IDX_W-1:0]      hmap_cfg;

   // Items waiting to be offered, and results the block still owes us.
   eq_req_type queued_ops [$];
   eq_rsp_type expected_maps [$];
   int         ops_queued = 0;
   int         error_count = 0;

   // Driver state.
   eq_req_type offered;
   int         gap_left = 0;
   int         drv_calm = 0;

   // Receiver state. A long hold is requested by bumping hold_requests; the
   // receiver serves each request once.
   int      ready_wait = 0;
   int      rsp_calm = 0;
   int      hold_left = 0;
   int      hold_requests = 0;
   int      hold_served = 0;

   int      cycle_count = 0;

   histogram_equalization_map_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Number of intensity levels for a given bits_allocated. Settings above the
   // store width behave as the store width.
   function automatic int level_count(input int bits);
      return 1 << ((bits > heqm_pkg::INTENSITY_BITS) ? heqm_pkg::INTENSITY_BITS : bits);
   endfunction

   function automatic logic [heqm_pkg::COUNT_BITS-1:0] count_add(
         input logic [heqm_pkg::COUNT_BITS-1:0] a,
         input logic [heqm_pkg::COUNT_BITS-1:0] b);
      logic [heqm_pkg::COUNT_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[heqm_pkg::COUNT_BITS] ? heqm_pkg::COUNT_MAX : s[heqm_pkg::COUNT_BITS-1:0];
   endfunction

   function automatic void wipe_store();
      for (int i = 0; i < heqm_pkg::STORE_DEPTH; i++) bin_count[i] = '0;
      sample_total = '0;
      cdf_floor    = '0;
      cdf_ready    = 1'b0;
   endfunction

   // Applies one item to the shadow state and returns the result the block
   // should produce for it.
   function automatic eq_rsp_type equalize(input eq_req_type it);
      eq_rsp_type                      r;
      longint unsigned                 levels;
      logic [heqm_pkg::COUNT_BITS-1:0] c;
      longint unsigned                 num;
      longint unsigned                 q;
      logic [heqm_pkg::COUNT_BITS-1:0] run;
      logic                            found;
      r.mapped = '0;
      r.status = heqm_pkg::ST_OK;
      levels   = 64'(level_count(int'(bits_cfg)));
      case (it.op)
         heqm_pkg::OP_ADD: begin
            // The store holds the cdf once finalized, so samples are dropped
            // until the next clear.
            if (cdf_ready || 64'(it.intensity) >= levels) begin
               r.status = heqm_pkg::ST_DROPPED;
            end else begin
               bin_count[it.intensity] = count_add(bin_count[it.intensity],
                                                   heqm_pkg::COUNT_BITS'(1));
               sample_total = count_add(sample_total, heqm_pkg::COUNT_BITS'(1));
            end
         end
         heqm_pkg::OP_FINAL: begin
            // The walk covers the whole store whatever bits_allocated says.
            if (!cdf_ready) begin
               run       = '0;
               found     = 1'b0;
               cdf_floor = '0;
               for (int i = 0; i < heqm_pkg::STORE_DEPTH; i++) begin
                  run = count_add(run, bin_count[i]);
                  bin_count[i] = run;
                  if (!found && run != '0) begin
                     cdf_floor = run;
                     found     = 1'b1;
                  end
               end
               cdf_ready = 1'b1;
            end
         end
         heqm_pkg::OP_QUERY: begin
            if (!cdf_ready) begin
               r.status = heqm_pkg::ST_NOT_FINAL;
            end else if (it.intensity > hmap_cfg) begin
               r.status = heqm_pkg::ST_BEYOND;
            end else begin
               c = bin_count[it.intensity];
               if (c != '0 && sample_total > cdf_floor && c >= cdf_floor) begin
                  num = 64'(c - cdf_floor) * (levels - 64'(1));
                  q   = num / 64'(sample_total - cdf_floor);
                  r.mapped = (q > 64'(4095)) ? heqm_pkg::MAP_W'(4095)
                                             : heqm_pkg::MAP_W'(q);
               end
            end
         end
         default: begin
            wipe_store();
         end
      endcase
      return r;
   endfunction

   // Driver: offers queued items one at a time. After each item it may leave a
   // gap, except during calm stretches where items go back to back.
   always @(posedge clock) begin : feed
      int         w;
      eq_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_maps.push_back(equalize(offered));
         end
         if (req_tvalid && !req_tready) begin
            // Keep the current item on the bus until the block takes it.
         end else if (gap_left != 0) begin
            req_tvalid <= 1'b0;
            gap_left   <= gap_left - 1;
         end else if (queued_ops.size() != 0) begin
            if (drv_calm != 0) begin
               w = 0;
               drv_calm <= drv_calm - 1;
            end else begin
               w = $urandom_range(0, 6);
               if ($urandom_range(0, 15) == 0) drv_calm <= $urandom_range(10, 30);
            end
            nxt = queued_ops.pop_front();
            offered    <= nxt;
            req_tdata  <= heqm_pkg::REQ_DW'(nxt);
            req_tvalid <= 1'b1;
            gap_left   <= w;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: checks every result against the oldest expectation, then
   // decides how long to hold off before taking the next one.
   always @(posedge clock) begin : collect
      int         w;
      eq_rsp_type got;
      eq_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_wait <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = eq_rsp_type'(rsp_tdata[heqm_pkg::MAP_W+heqm_pkg::STAT_W-1:0]);
            if (expected_maps.size() == 0) begin
               $error("result item with none expected: mapped_value %0d, status %0d",
                      got.mapped, got.status);
               error_count++;
            end else begin
               want = expected_maps.pop_front();
               if (got.mapped !== want.mapped) begin
                  $error("mapped_value: expected %0d, got %0d", want.mapped, got.mapped);
                  error_count++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  error_count++;
               end
            end
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            hold_left  <= hold_left - 1;
         end else if (hold_served != hold_requests) begin
            // Long stall: the block fills up and has to back-pressure its input.
            rsp_tready  <= 1'b0;
            hold_left   <= LONG_HOLD;
            hold_served <= hold_served + 1;
         end else if (rsp_tvalid && rsp_tready) begin
            if (rsp_calm != 0) begin
               w = 0;
               rsp_calm <= rsp_calm - 1;
            end else begin
               w = $urandom_range(0, 6);
               if ($urandom_range(0, 15) == 0) rsp_calm <= $urandom_range(10, 30);
            end
            rsp_tready <= (w == 0);
            ready_wait <= (w > 0) ? w - 1 : 0;
         end else if (ready_wait != 0) begin
            rsp_tready <= 1'b0;
            ready_wait <= ready_wait - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog. The limit is far above the slowest correct run, which is
   // dominated by the post-reset sweep, the finalize and clear walks and the
   // long receiver holds.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic queue_op(input heqm_pkg::op_type op, input int v);
      eq_req_type it;
      it.op        = op;
      it.intensity = heqm_pkg::IDX_W'(v);
      queued_ops.push_back(it);
      ops_queued++;
   endtask

   // Waits until every queued item has been taken and every result has come
   // back, then lets a few more cycles pass so the block is surely idle.
   task automatic drain(input int settle);
      @(negedge clock);
      while (queued_ops.size() != 0 || req_tvalid || expected_maps.size() != 0)
         @(negedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Writes both registers on consecutive edges and mirrors them in the shadow
   // copy. Called after a drain, except the first call, during the post-reset sweep.
   task automatic program_regs(input int bits, input int hmap);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= heqm_pkg::CSR_BITS;
      csr_wdata <= heqm_pkg::CSR_DW'(bits);
      bits_cfg = heqm_pkg::BITS_W'(bits);
      @(posedge clock);
      csr_index <= heqm_pkg::CSR_HMAP;
      csr_wdata <= heqm_pkg::CSR_DW'(hmap);
      hmap_cfg = heqm_pkg::IDX_W'(hmap);
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   initial begin : stimulus
      int b;
      int h;
      int lv;
      int hot;
      int n;
      int r;
      int phase;
      int random_start;
      wipe_store();
      bits_cfg = heqm_pkg::BITS_RESET;
      hmap_cfg = heqm_pkg::HMAP_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part, full width. The block is still sweeping its store after
      // reset; the driver simply waits for req_tready.
      program_regs(12, 4095);
      queue_op(heqm_pkg::OP_QUERY, 7);        // query before finalize
      queue_op(heqm_pkg::OP_ADD, 0);          // lowest intensity
      queue_op(heqm_pkg::OP_ADD, 4095);       // highest intensity, twice
      queue_op(heqm_pkg::OP_ADD, 4095);
      queue_op(heqm_pkg::OP_ADD, 100);
      queue_op(heqm_pkg::OP_ADD, 'hAAA);
      queue_op(heqm_pkg::OP_ADD, 'h555);
      queue_op(heqm_pkg::OP_FINAL, 0);
      queue_op(heqm_pkg::OP_FINAL, 0);        // second finalize does nothing
      queue_op(heqm_pkg::OP_ADD, 5);          // add after finalize is dropped
      queue_op(heqm_pkg::OP_QUERY, 0);        // cdf equals cdfmin, maps to zero
      queue_op(heqm_pkg::OP_QUERY, 4095);     // top of the scale
      queue_op(heqm_pkg::OP_QUERY, 100);
      queue_op(heqm_pkg::OP_QUERY, 2000);
      queue_op(heqm_pkg::OP_CLEAR, 4095);
      queue_op(heqm_pkg::OP_QUERY, 100);      // cleared, so not finalized again
      queue_op(heqm_pkg::OP_FINAL, 0);        // finalize over an empty store
      queue_op(heqm_pkg::OP_QUERY, 5);        // zero cdf
      drain(4);

      // Zero bits and zero limit: only intensity 0 counts, and a single sample
      // leaves a zero divisor.
      program_regs(0, 0);
      queue_op(heqm_pkg::OP_ADD, 0);
      queue_op(heqm_pkg::OP_ADD, 1);          // beyond the allocated bits
      queue_op(heqm_pkg::OP_FINAL, 0);
      queue_op(heqm_pkg::OP_QUERY, 0);
      queue_op(heqm_pkg::OP_QUERY, 1);        // beyond highest_mapped
      queue_op(heqm_pkg::OP_CLEAR, 0);

      // Random part. Each phase picks a register setting, mostly at the
      // extremes, and then runs either a well-formed histogram build (clear,
      // adds, finalize, queries) with random content or a burst of noise.
      phase        = 0;
      random_start = ops_queued;
      while (ops_queued - random_start < RANDOM_OPS) begin
         drain(4);
         r = $urandom_range(0, 5);
         case (r)
            0:       b = 0;
            1:       b = 1;
            2:       b = 12;
            3:       b = 15;
            default: b = $urandom_range(0, 15);
         endcase
         lv = level_count(b);
         r = $urandom_range(0, 4);
         case (r)
            0:       h = 0;
            1:       h = 4095;
            2:       h = lv - 1;
            default: h = $urandom_range(0, 4095);
         endcase
         program_regs(b, h);
         // A few early phases run against a receiver that stalls for longer
         // than a whole store walk, so results pile up even behind a clear.
         if (phase >= 1 && phase <= 3) hold_requests++;
         hot = $urandom_range(0, lv - 1);
         if ($urandom_range(0, 9) < 8) begin
            queue_op(heqm_pkg::OP_CLEAR, $urandom_range(0, 4095));
            n = $urandom_range(1, 40);
            repeat (n) begin
               r = $urandom_range(0, 9);
               if (r < 6) queue_op(heqm_pkg::OP_ADD, $urandom_range(0, lv - 1));
               else if (r < 8) queue_op(heqm_pkg::OP_ADD, hot);
               else queue_op(heqm_pkg::OP_ADD, $urandom_range(0, 4095));
            end
            if ($urandom_range(0, 3) == 0)
               queue_op(heqm_pkg::OP_QUERY, $urandom_range(0, 4095));
            queue_op(heqm_pkg::OP_FINAL, $urandom_range(0, 4095));
            if ($urandom_range(0, 3) == 0)
               queue_op(heqm_pkg::OP_FINAL, $urandom_range(0, 4095));
            if ($urandom_range(0, 3) == 0)
               queue_op(heqm_pkg::OP_ADD, $urandom_range(0, lv - 1));
            n = $urandom_range(1, 20);
            repeat (n) begin
               r = $urandom_range(0, 9);
               if (r < 7) queue_op(heqm_pkg::OP_QUERY, $urandom_range(0, h));
               else if (r < 8) queue_op(heqm_pkg::OP_QUERY, hot);
               else queue_op(heqm_pkg::OP_QUERY, $urandom_range(0, 4095));
            end
         end else begin
            // Noise: the slow operations are kept rare since each one walks the
            // whole store.
            n = $urandom_range(5, 15);
            repeat (n) begin
               r = $urandom_range(0, 15);
               if (r == 0) queue_op(heqm_pkg::OP_FINAL, $urandom_range(0, 4095));
               else if (r == 1) queue_op(heqm_pkg::OP_CLEAR, $urandom_range(0, 4095));
               else if (r < 9) queue_op(heqm_pkg::OP_ADD, $urandom_range(0, 4095));
               else queue_op(heqm_pkg::OP_QUERY, $urandom_range(0, 4095));
            end
         end
         phase++;
      end

      // Let the last results arrive, then give the block a few more cycles in
      // which any stray result would be flagged by the receiver.
      drain(0);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
